[rtl/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// same-cycle implication
`define ASSERT_IMPL(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`endif

[rtl/lzwc_pkg.sv]
`default_nettype none
package lzwc_pkg;
    localparam int BYTE_W = 8;
    localparam int PACK_W = 32;
    typedef logic [1:0] sel_t;
    localparam sel_t SEL_MISS = 2'd0;
    localparam sel_t SEL_CUR  = 2'd1;
    localparam sel_t SEL_MAX  = 2'd2;
    localparam sel_t SEL_ZERO = 2'd3;
endpackage
`default_nettype wire

[rtl/lzwc_ram.sv]
`default_nettype none
module lzwc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

[rtl/lzw_compressor_15bit.sv]
`default_nettype none
`include "assert_macros.svh"
// LZW compressor with fixed CODE_WIDTH-bit codes, packed MSB first into bytes. One input
// word is one raw byte; tlast marks the final byte of a stream, which also emits the end
// codes (current string, all-ones, zero) and drops fewer than 8 leftover bits. The
// dictionary is a hash table in one single-port-read RAM. The first byte of a stream is only
// accepted unless it is final. Any other byte is accepted, then hashed (plus a reduction step
// per subtraction of HASH_ENTRIES, none at the default sizes), then probed in the table (read,
// check per probe); each code is pushed then drained byte by byte, held while the output stalls.
// After reset and after every final byte the whole table is swept clear;
// during the sweep no input is taken.
// m_axis_tlast marks the last output byte caused by an input word; m_axis_tuser marks the
// last byte of the whole stream.
module lzw_compressor_15bit
    import lzwc_pkg::*;
#(
    parameter int CODE_WIDTH   = 15,
    parameter int HASH_ENTRIES = 32771
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       s_axis_tvalid,
    output logic            s_axis_tready,
    input  wire logic [7:0] s_axis_tdata,   // [7:0] in_byte
    input  wire logic       s_axis_tlast,   // is_final
    output logic            m_axis_tvalid,
    input  wire logic       m_axis_tready,
    output logic      [7:0] m_axis_tdata,   // [7:0] out_byte
    output logic            m_axis_tlast,   // run_last
    output logic      [0:0] m_axis_tuser    // [0] stream_done
);
    localparam int CW = CODE_WIDTH;
    localparam int IW = $clog2(HASH_ENTRIES);
    localparam int HW = (CW > IW) ? CW : IW;
    localparam int RW = 1 + 2 * CW + BYTE_W;
    localparam int SHW = $clog2(PACK_W + 1);
    localparam logic [HW-1:0] HE_H = HW'(HASH_ENTRIES);
    localparam logic [IW-1:0] HE_I = IW'(HASH_ENTRIES);
    localparam logic [IW-1:0] HE_LAST = IW'(HASH_ENTRIES - 1);
    localparam logic [CW-1:0] CODE_MAX = {CW{1'b1}};
    localparam logic [CW-1:0] CODE_FIRST = CW'(256);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_HASH  = 3'd2;
    localparam logic [2:0] S_READ  = 3'd3;
    localparam logic [2:0] S_CHECK = 3'd4;
    localparam logic [2:0] S_PUSH  = 3'd5;
    localparam logic [2:0] S_DRAIN = 3'd6;

    logic [2:0]        state_reg, state_next;
    logic [IW-1:0]     idx_reg, idx_next;
    logic [IW-1:0]     step_reg, step_next;
    logic [IW-1:0]     cnt_reg, cnt_next;
    logic [HW-1:0]     hval_reg, hval_next;
    logic [CW-1:0]     cur_reg, cur_next;
    logic [CW-1:0]     miss_reg, miss_next;
    logic [CW-1:0]     free_reg, free_next;
    logic              first_reg, first_next;
    logic [7:0]        ch_reg, ch_next;
    logic              fin_reg, fin_next;
    sel_t              sel_reg, sel_next;
    logic [PACK_W-1:0] bits_reg, bits_next;
    logic [4:0]        count_reg, count_next;
    logic              ov_reg, ov_next;
    logic [7:0]        od_reg, od_next;
    logic              ol_reg, ol_next;
    logic              ou_reg, ou_next;

    logic          ram_we;
    logic [IW-1:0] ram_waddr;
    logic [RW-1:0] ram_wdata;
    logic [RW-1:0] rd;
    logic          rd_used;
    logic [CW-1:0] rd_code, rd_prefix;
    logic [7:0]    rd_char;
    logic          rd_hit;
    logic [IW-1:0] idx_adv;
    logic [CW-1:0] push_code;
    logic          more;
    logic [SHW-1:0] sh;
    logic [4:0]    count_after;

    lzwc_ram #(.WIDTH(RW), .DEPTH(HASH_ENTRIES)) u_table (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(idx_reg),
        .rdata(rd)
    );

    assign rd_used   = rd[RW-1];
    assign rd_code   = rd[RW-2 -: CW];
    assign rd_prefix = rd[CW+7 -: CW];
    assign rd_char   = rd[7:0];
    assign rd_hit    = rd_used && (rd_prefix == cur_reg) && (rd_char == ch_reg);
    assign idx_adv   = (idx_reg >= step_reg) ? (idx_reg - step_reg)
                                             : (idx_reg + HE_I - step_reg);
    assign more      = (sel_reg == SEL_MISS) ? fin_reg : (sel_reg != SEL_ZERO);
    assign sh        = SHW'(PACK_W - CW) - SHW'(count_reg);
    assign count_after = count_reg - 5'd8;

    always_comb
    begin
        case (sel_reg)
            SEL_MISS: push_code = miss_reg;
            SEL_CUR:  push_code = cur_reg;
            SEL_MAX:  push_code = CODE_MAX;
            default:  push_code = '0;
        endcase
    end

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = ov_reg;
    assign m_axis_tdata  = od_reg;
    assign m_axis_tlast  = ol_reg;
    assign m_axis_tuser  = ou_reg;

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        step_next  = step_reg;
        cnt_next   = cnt_reg;
        hval_next  = hval_reg;
        cur_next   = cur_reg;
        miss_next  = miss_reg;
        free_next  = free_reg;
        first_next = first_reg;
        ch_next    = ch_reg;
        fin_next   = fin_reg;
        sel_next   = sel_reg;
        bits_next  = bits_reg;
        count_next = count_reg;
        ov_next    = ov_reg && !m_axis_tready;
        od_next    = od_reg;
        ol_next    = ol_reg;
        ou_next    = ou_reg;
        ram_we     = 1'b0;
        ram_waddr  = idx_reg;
        ram_wdata  = {1'b1, free_reg, cur_reg, ch_reg};

        case (state_reg)
            S_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_wdata = '0;
                idx_next  = idx_reg + IW'(1);
                if (idx_reg == HE_LAST)
                begin
                    idx_next   = '0;
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    ch_next  = s_axis_tdata;
                    fin_next = s_axis_tlast;
                    if (first_reg)
                    begin
                        cur_next   = CW'(s_axis_tdata);
                        first_next = 1'b0;
                        sel_next   = SEL_CUR;
                        state_next = s_axis_tlast ? S_PUSH : S_IDLE;
                    end
                    else
                    begin
                        hval_next  = (HW'(s_axis_tdata) << (CW - 8)) ^ HW'(cur_reg);
                        state_next = S_HASH;
                    end
                end
            end
            S_HASH:
            begin
                if (hval_reg >= HE_H)
                begin
                    hval_next = hval_reg - HE_H;
                end
                else
                begin
                    idx_next   = hval_reg[IW-1:0];
                    step_next  = (hval_reg == '0) ? IW'(1) : (HE_I - hval_reg[IW-1:0]);
                    cnt_next   = '0;
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (rd_hit)
                begin
                    cur_next   = rd_code;
                    sel_next   = SEL_CUR;
                    state_next = fin_reg ? S_PUSH : S_IDLE;
                end
                else if (!rd_used || cnt_reg == HE_LAST)
                begin
                    if (!rd_used && free_reg != CODE_MAX)
                    begin
                        ram_we    = 1'b1;
                        free_next = free_reg + CW'(1);
                    end
                    miss_next  = cur_reg;
                    cur_next   = CW'(ch_reg);
                    sel_next   = SEL_MISS;
                    state_next = S_PUSH;
                end
                else
                begin
                    idx_next   = idx_adv;
                    cnt_next   = cnt_reg + IW'(1);
                    state_next = S_READ;
                end
            end
            S_PUSH:
            begin
                bits_next  = bits_reg | (PACK_W'(push_code) << sh);
                count_next = count_reg + 5'(CW);
                state_next = S_DRAIN;
            end
            S_DRAIN:
            begin
                if (count_reg >= 5'd8)
                begin
                    if (!ov_reg || m_axis_tready)
                    begin
                        ov_next    = 1'b1;
                        od_next    = bits_reg[PACK_W-1 -: 8];
                        ol_next    = (count_after < 5'd8) && !more;
                        ou_next    = (count_after < 5'd8) && !more && fin_reg;
                        bits_next  = bits_reg << 8;
                        count_next = count_after;
                    end
                end
                else if (more)
                begin
                    sel_next   = sel_t'(sel_reg + 2'd1);
                    state_next = S_PUSH;
                end
                else if (fin_reg)
                begin
                    free_next  = CODE_FIRST;
                    cur_next   = '0;
                    first_next = 1'b1;
                    bits_next  = '0;
                    count_next = '0;
                    idx_next   = '0;
                    state_next = S_CLEAR;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
                idx_next   = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            idx_reg   <= '0;
            step_reg  <= '0;
            cnt_reg   <= '0;
            cur_reg   <= '0;
            free_reg  <= CODE_FIRST;
            first_reg <= 1'b1;
            fin_reg   <= 1'b0;
            sel_reg   <= SEL_MISS;
            bits_reg  <= '0;
            count_reg <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            step_reg  <= step_next;
            cnt_reg   <= cnt_next;
            cur_reg   <= cur_next;
            free_reg  <= free_next;
            first_reg <= first_next;
            fin_reg   <= fin_next;
            sel_reg   <= sel_next;
            bits_reg  <= bits_next;
            count_reg <= count_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hval_reg <= hval_next;
        miss_reg <= miss_next;
        ch_reg   <= ch_next;
        od_reg   <= od_next;
        ol_reg   <= ol_next;
        ou_reg   <= ou_next;
    end

    `ASSERT_IMPL(a_idle_pack, clk, rst_n, state_reg == S_IDLE, count_reg < 5'd8)
    `ASSERT_IMPL(a_free_min, clk, rst_n, 1'b1, free_reg >= CODE_FIRST)
    `ASSERT_NEXT(a_hit_cur, clk, rst_n, state_reg == S_CHECK && rd_hit,
                 cur_reg == $past(rd_code))
    `ASSERT_NEXT(a_clear_done, clk, rst_n, state_reg == S_CLEAR && idx_reg == HE_LAST,
                 state_reg == S_IDLE && first_reg)
endmodule
`default_nettype wire

[bench/tb.sv]
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import lzwc_pkg::*;

    localparam int CW       = 15;
    localparam int SLOTS    = 32771;
    localparam int CODE_END = (1 << CW) - 1;
    localparam int LIMIT    = 4000000;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       done;
    } out_word_t;

    class lzw_scoreboard;
        bit              used[SLOTS];
        logic [CW-1:0]   code[SLOTS];
        logic [CW-1:0]   prefix[SLOTS];
        logic [7:0]      chr[SLOTS];
        int              free_code;
        logic [CW-1:0]   cur;
        bit              fresh;
        logic [31:0]     pbits;
        int              pcnt;
        out_word_t       pending[$];
        logic [7:0]      burst[$];
        int              hits;
        int              words_out;

        function void clear();
            foreach (used[i]) used[i] = 0;
            free_code = 256;
            cur = '0;
            fresh = 1;
            pbits = '0;
            pcnt = 0;
        endfunction

        function void push_code(logic [CW-1:0] c);
            pbits |= 32'(c) << (32 - CW - pcnt);
            pcnt += CW;
            while (pcnt >= 8) begin
                burst.push_back(pbits[31:24]);
                pbits <<= 8;
                pcnt -= 8;
            end
        endfunction

        function void note_input(logic [7:0] b, logic fin);
            int idx;
            int step;
            int n;
            int found;
            out_word_t w;
            burst.delete();
            if (fresh) begin
                cur = CW'(b);
                fresh = 0;
            end
            else begin
                idx = ((int'(b) << (CW - 8)) ^ int'(cur)) % SLOTS;
                step = (idx == 0) ? 1 : SLOTS - idx;
                found = -1;
                for (n = 0; n < SLOTS; n++) begin
                    if (!used[idx]) begin
                        found = 0;
                        break;
                    end
                    if (prefix[idx] == cur && chr[idx] == b) begin
                        found = 1;
                        break;
                    end
                    idx = (idx >= step) ? idx - step : idx + SLOTS - step;
                end
                if (found == 1) begin
                    cur = code[idx];
                    hits++;
                end
                else begin
                    if (found == 0 && free_code <= CODE_END - 1) begin
                        used[idx] = 1;
                        code[idx] = CW'(free_code);
                        prefix[idx] = cur;
                        chr[idx] = b;
                        free_code++;
                    end
                    push_code(cur);
                    cur = CW'(b);
                end
            end
            if (fin) begin
                push_code(cur);
                push_code(CW'(CODE_END));
                push_code('0);
            end
            foreach (burst[k]) begin
                w.data = burst[k];
                w.last = (k == burst.size() - 1);
                w.done = w.last && fin;
                pending.push_back(w);
            end
            if (fin) clear();
        endfunction

        function string check(logic [7:0] d, logic l, logic u);
            out_word_t e;
            words_out++;
            if (pending.size() == 0)
                return $sformatf("unexpected word %02h", d);
            e = pending.pop_front();
            if (d !== e.data || l !== e.last || u !== e.done)
                return $sformatf("got %02h/%0b/%0b exp %02h/%0b/%0b",
                                 d, l, u, e.data, e.last, e.done);
            return "";
        endfunction
    endclass

    logic       clk = 0;
    logic       rst_n = 0;
    logic       s_axis_tvalid = 0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata = '0;
    logic       s_axis_tlast = 0;
    logic       m_axis_tvalid;
    logic       m_axis_tready = 0;
    logic [7:0] m_axis_tdata;
    logic       m_axis_tlast;
    logic [0:0] m_axis_tuser;

    lzw_compressor_15bit dut (.*);

    always
    begin
        #5 clk = 1;
        #5 clk = 0;
    end

    lzw_scoreboard sb = new();
    int  errors;
    int  cycles;
    int  items;
    int  streams;
    bit  no_idle;
    bit  hold_off;

    task automatic report(string msg);
        $display("ERROR @%0t: %s", $time, msg);
        errors++;
    endtask

    // every finished stream adds a table sweep
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT + 4 * SLOTS * streams)
        begin
            $display("timeout");
            $display("Simulation FAILED");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        string msg;
        if (rst_n && s_axis_tvalid && s_axis_tready)
            sb.note_input(s_axis_tdata, s_axis_tlast);
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            msg = sb.check(m_axis_tdata, m_axis_tlast, m_axis_tuser[0]);
            if (msg != "") report(msg);
        end
    end

    always @(posedge clk)
        m_axis_tready <= !hold_off && (no_idle || $urandom_range(99) >= 32);

    initial
    begin
        hold_off = 0;
        wait (items >= 120);
        hold_off = 1;
        repeat (400) @(posedge clk);
        hold_off = 0;
    end

    task automatic send(logic [7:0] b, logic fin);
        while (!no_idle && $urandom_range(99) < 32)
        begin
            s_axis_tvalid <= 0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1;
        s_axis_tdata <= b;
        s_axis_tlast <= fin;
        do @(posedge clk); while (!s_axis_tready);
        items++;
        if (fin) streams++;
    endtask

    task automatic send_stream(int len, int alpha);
        logic [7:0] base;
        base = 8'($urandom);
        for (int i = 0; i < len; i++)
            send((alpha >= 256) ? 8'($urandom) : base + 8'($urandom_range(alpha - 1)),
                 i == len - 1);
    endtask

    initial
    begin
        sb.clear();
        repeat (9) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);
        // single-byte streams at the extremes
        send(8'h00, 1);
        send(8'hFF, 1);
        // repeated pair builds growing dictionary hits
        for (int i = 0; i < 12; i++) send((i % 2) ? 8'hAA : 8'h55, i == 11);
        send(8'h00, 0);
        send(8'h00, 0);
        send(8'hFF, 0);
        send(8'hFF, 0);
        send(8'h00, 1);
        while (items < 410)
        begin
            no_idle = (streams == 5 || streams == 6);
            case ($urandom_range(3))
                0: send_stream($urandom_range(1, 8), 256);
                1: send_stream($urandom_range(20, 60), 2);
                2: send_stream($urandom_range(20, 60), 4);
                default: send_stream($urandom_range(10, 40), 256);
            endcase
        end
        s_axis_tvalid <= 0;
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (100) @(posedge clk);
        $display("%0d bytes in %0d streams, %0d dictionary hits, %0d words out",
                 items, streams, sb.hits, sb.words_out);
        if (errors == 0 && sb.pending.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule

`default_nettype wire

[files.f]
+incdir+rtl
rtl/lzwc_pkg.sv
rtl/lzwc_ram.sv
rtl/lzw_compressor_15bit.sv
bench/tb.sv
